FILE: sv/kar_pkg.sv
// ----------------------------------------------------------------------------
// kar_pkg
// shared widths, register indexes, reset values and types for the
// two-button key auto repeat block
// ----------------------------------------------------------------------------
package kar_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 2;
    // compare width covers both the timers and the settings
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    localparam logic [IDX_W-1:0] REG_DEBOUNCE      = 2'd0;
    localparam logic [IDX_W-1:0] REG_INITIAL_DELAY = 2'd1;
    localparam logic [IDX_W-1:0] REG_REPEAT        = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd50;
    localparam logic [CFG_W-1:0] INITIAL_DELAY_RST = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_RST        = 16'd100;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] initial_delay_ms;
        logic [CFG_W-1:0] repeat_ms;
    } t_cfg;

endpackage

FILE: sv/kar_intf.sv
// ----------------------------------------------------------------------------
// kar channel interfaces
// valid/ready channels for ticks, results and register writes
// ----------------------------------------------------------------------------
interface kar_in_if;
    logic valid;
    logic ready;
    logic button_a_level;
    logic button_b_level;
    modport source (output valid, output button_a_level, output button_b_level,
                    input ready);
    modport sink   (input valid, input button_a_level, input button_b_level,
                    output ready);
endinterface

interface kar_out_if;
    logic valid;
    logic ready;
    logic key_a_event;
    logic key_b_event;
    modport source (output valid, output key_a_event, output key_b_event,
                    input ready);
    modport sink   (input valid, input key_a_event, input key_b_event,
                    output ready);
endinterface

interface kar_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [kar_pkg::IDX_W-1:0] index;
    logic [kar_pkg::CFG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/kar_button.sv
// ----------------------------------------------------------------------------
// kar_button
// debounce sampling and typematic repeat state of one button
// ----------------------------------------------------------------------------
module kar_button (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kar_pkg::t_cfg i_cfg,
    input  logic          i_step,
    input  logic          i_level,
    output logic          o_event
);

    logic [kar_pkg::TIMER_BITS-1:0] r_sample_elapsed, n_sample_elapsed;
    logic [kar_pkg::TIMER_BITS-1:0] r_repeat_elapsed, n_repeat_elapsed;
    logic                           r_held, n_held;
    logic                           r_in_first_delay, n_in_first_delay;

    logic [kar_pkg::TIMER_BITS-1:0] sample_inc, repeat_inc;
    logic [kar_pkg::CMP_W-1:0]      sample_x, repeat_x;
    logic [kar_pkg::CMP_W-1:0]      deb_x, init_x, rpt_x;

    always_comb begin
        sample_inc = (r_sample_elapsed == kar_pkg::CNT_MAX) ? r_sample_elapsed
                                                           : r_sample_elapsed + 1'b1;
        repeat_inc = (r_repeat_elapsed == kar_pkg::CNT_MAX) ? r_repeat_elapsed
                                                           : r_repeat_elapsed + 1'b1;
        sample_x = kar_pkg::CMP_W'(sample_inc);
        repeat_x = kar_pkg::CMP_W'(repeat_inc);
        deb_x    = kar_pkg::CMP_W'(i_cfg.debounce_ms);
        init_x   = kar_pkg::CMP_W'(i_cfg.initial_delay_ms);
        rpt_x    = kar_pkg::CMP_W'(i_cfg.repeat_ms);

        n_sample_elapsed = sample_inc;
        n_repeat_elapsed = repeat_inc;
        n_held           = r_held;
        n_in_first_delay = r_in_first_delay;
        o_event          = 1'b0;

        if (sample_x > deb_x) begin
            n_sample_elapsed = '0;
            if (!i_level) begin
                if (!r_held) begin
                    // first press
                    n_held           = 1'b1;
                    n_in_first_delay = 1'b1;
                    n_repeat_elapsed = '0;
                    o_event          = 1'b1;
                end else if (r_in_first_delay) begin
                    // enter repeat mode silently
                    if (repeat_x > init_x) begin
                        n_in_first_delay = 1'b0;
                        n_repeat_elapsed = '0;
                    end
                end else if (repeat_x > rpt_x) begin
                    n_repeat_elapsed = '0;
                    o_event          = 1'b1;
                end
            end else begin
                n_held = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_elapsed <= '0;
            r_repeat_elapsed <= '0;
            r_held           <= 1'b0;
            r_in_first_delay <= 1'b1;
        end else if (i_step) begin
            r_sample_elapsed <= n_sample_elapsed;
            r_repeat_elapsed <= n_repeat_elapsed;
            r_held           <= n_held;
            r_in_first_delay <= n_in_first_delay;
        end
    end

endmodule

FILE: sv/key_auto_repeat_two_buttons.sv
// ----------------------------------------------------------------------------
// key_auto_repeat_two_buttons
// typematic auto repeat for two active-low buttons, one tick per item
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one millisecond tick per item with the raw levels of
//   buttons a and b (0 = pressed). o_out returns exactly one item per tick
//   with the key event flags of both buttons.
//   i_cfg writes register 0 debounce_ms, 1 initial_delay_ms, 2 repeat_ms;
//   other indexes are ignored. it is always ready; the user must write it
//   only while the block is idle, which the block itself does not enforce.
// latency and throughput:
//   a tick accepted at one edge is registered and shows its result at o_out
//   from the next cycle on. one tick per cycle is accepted while o_out is not
//   stalled, set by the per-button state update and the single output register.
// reset:
//   i_rst_n (synchronous, low) clears the counters and held flags, sets the
//   first delay phase and loads the settings 50 / 500 / 100.
// stall:
//   while o_out is valid and not taken the result holds and i_in.ready
//   drops; it returns as soon as the result is taken, in that same cycle.
// ----------------------------------------------------------------------------
module key_auto_repeat_two_buttons (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kar_in_if.sink   i_in,
    kar_out_if.source o_out,
    kar_cfg_if.sink  i_cfg
);

    kar_pkg::t_cfg r_cfg;
    logic          r_out_valid;
    logic          r_key_a, r_key_b;
    logic          in_acc;
    logic          ev_a, ev_b;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= kar_pkg::DEBOUNCE_RST;
            r_cfg.initial_delay_ms <= kar_pkg::INITIAL_DELAY_RST;
            r_cfg.repeat_ms        <= kar_pkg::REPEAT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                kar_pkg::REG_DEBOUNCE:      r_cfg.debounce_ms      <= i_cfg.data;
                kar_pkg::REG_INITIAL_DELAY: r_cfg.initial_delay_ms <= i_cfg.data;
                kar_pkg::REG_REPEAT:        r_cfg.repeat_ms        <= i_cfg.data;
                default: ;
            endcase
        end
    end

    kar_button u_button_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (in_acc),
        .i_level (i_in.button_a_level),
        .o_event (ev_a)
    );

    kar_button u_button_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (in_acc),
        .i_level (i_in.button_b_level),
        .o_event (ev_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key_a <= ev_a;
            r_key_b <= ev_b;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.key_a_event = r_key_a;
    assign o_out.key_b_event = r_key_b;

    // a tick always leaves a result behind
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out.valid)
        else $error("accepted item left no result");

    // no tick is taken while an untaken result would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input ready while result stalled");

    // without a new tick a taken result is not replaced by another
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !in_acc) |=> !o_out.valid)
        else $error("result appeared without an item");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the two-button key auto repeat block tick by tick against an
// in-bench model of the debounce, first delay and repeat timers, under
// random gaps on both channels and a long output hold-off
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [kar_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic key_a_event;
        logic key_b_event;
    } t_keys;

    typedef struct packed {
        logic [kar_pkg::TIMER_BITS-1:0] sample_age;
        logic [kar_pkg::TIMER_BITS-1:0] hold_age;
        logic                           held;
        logic                           first_delay;
    } t_button;

    logic i_clk;
    logic i_rst_n;

    kar_in_if  in_ch ();
    kar_out_if out_ch ();
    kar_cfg_if cfg_ch ();

    key_auto_repeat_two_buttons dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    t_button        buttons [2];
    kar_pkg::t_cfg  settings;
    t_keys          keys_due [$];
    int             src_idle_pct;
    int             snk_idle_pct;
    int             hold_off_cycles;
    int unsigned    mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("** key_auto_repeat_two_buttons: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // timer model
    // ------------------------------------------------------------------
    function automatic void reset_timers();
        settings.debounce_ms      = kar_pkg::DEBOUNCE_RST;
        settings.initial_delay_ms = kar_pkg::INITIAL_DELAY_RST;
        settings.repeat_ms        = kar_pkg::REPEAT_RST;
        for (int b = 0; b < 2; b++) begin
            buttons[b].sample_age  = '0;
            buttons[b].hold_age    = '0;
            buttons[b].held        = 1'b0;
            buttons[b].first_delay = 1'b1;
        end
    endfunction

    function automatic logic button_step(input int b, input logic level);
        logic fire;
        fire = 1'b0;
        if (buttons[b].sample_age != kar_pkg::CNT_MAX) buttons[b].sample_age++;
        if (buttons[b].hold_age != kar_pkg::CNT_MAX) buttons[b].hold_age++;
        if (buttons[b].sample_age > settings.debounce_ms) begin
            if (!level) begin
                if (!buttons[b].held) begin
                    buttons[b].held        = 1'b1;
                    buttons[b].first_delay = 1'b1;
                    buttons[b].hold_age    = '0;
                    fire                   = 1'b1;
                end else if (buttons[b].first_delay) begin
                    // end of first delay switches to repeat mode silently
                    if (buttons[b].hold_age > settings.initial_delay_ms) begin
                        buttons[b].first_delay = 1'b0;
                        buttons[b].hold_age    = '0;
                    end
                end else if (buttons[b].hold_age > settings.repeat_ms) begin
                    buttons[b].hold_age = '0;
                    fire                = 1'b1;
                end
            end else begin
                buttons[b].held = 1'b0;
            end
            buttons[b].sample_age = '0;
        end
        return fire;
    endfunction

    // ------------------------------------------------------------------
    // result side: random ready, long hold-off, compare with oldest item
    // ------------------------------------------------------------------
    initial begin
        t_keys want;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (keys_due.size() == 0) begin
                    $error("result item with nothing expected: a=%0b b=%0b",
                           out_ch.key_a_event, out_ch.key_b_event);
                    mismatches++;
                end else begin
                    want = keys_due.pop_front();
                    if (out_ch.key_a_event !== want.key_a_event) begin
                        $error("key_a_event: expected %0b, got %0b",
                               want.key_a_event, out_ch.key_a_event);
                        mismatches++;
                    end
                    if (out_ch.key_b_event !== want.key_b_event) begin
                        $error("key_b_event: expected %0b, got %0b",
                               want.key_b_event, out_ch.key_b_event);
                        mismatches++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // tick and register channels
    // ------------------------------------------------------------------
    // valid stays high after an item; gaps and drain lower it
    task automatic send_tick(input logic a_level, input logic b_level);
        t_keys keys;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.button_a_level <= a_level;
        in_ch.button_b_level <= b_level;
        do @(posedge i_clk); while (!in_ch.ready);
        keys.key_a_event = button_step(0, a_level);
        keys.key_b_event = button_step(1, b_level);
        keys_due.push_back(keys);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (keys_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kar_pkg::IDX_W-1:0] idx,
                             input logic [kar_pkg::CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            kar_pkg::REG_DEBOUNCE:      settings.debounce_ms      = val;
            kar_pkg::REG_INITIAL_DELAY: settings.initial_delay_ms = val;
            kar_pkg::REG_REPEAT:        settings.repeat_ms        = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [kar_pkg::CFG_W-1:0] debounce,
                              input logic [kar_pkg::CFG_W-1:0] delay,
                              input logic [kar_pkg::CFG_W-1:0] period);
        drain();
        write_reg(kar_pkg::REG_DEBOUNCE, debounce);
        write_reg(kar_pkg::REG_INITIAL_DELAY, delay);
        write_reg(kar_pkg::REG_REPEAT, period);
        // unused index must leave every setting alone
        write_reg(REG_UNUSED, kar_pkg::CFG_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // long level runs per button with one-tick bounces mixed in
    task automatic run_random(input int n, input int cap);
        logic [1:0] lvl;
        logic [1:0] tick;
        int         left [2];
        int         max_run;
        max_run = 2 * (settings.debounce_ms + 1) + settings.initial_delay_ms
                  + 3 * (settings.repeat_ms + 1);
        if (max_run > cap) max_run = cap;
        lvl     = 2'($urandom);
        left[0] = $urandom_range(max_run, 1);
        left[1] = $urandom_range(max_run, 1);
        for (int i = 0; i < n; i++) begin
            tick = lvl;
            for (int b = 0; b < 2; b++) begin
                if ($urandom_range(99) < 8) tick[b] = ~tick[b];
                left[b]--;
                if (left[b] == 0) begin
                    lvl[b]  = ~lvl[b];
                    left[b] = $urandom_range(max_run, 1);
                end
            end
            send_tick(tick[0], tick[1]);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [1:0] seq [14];
        // bit 0 is button a, bit 1 is button b, 0 means pressed
        seq = '{2'b11, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10,
                2'b01, 2'b00, 2'b00, 2'b11, 2'b00, 2'b00, 2'b01};
        src_idle_pct = 20;
        snk_idle_pct = 49;
        set_config(16'd0, 16'd2, 16'd1);
        foreach (seq[i]) send_tick(seq[i][0], seq[i][1]);
        // zero settings: press, mode change, then an item every tick
        set_config(16'd0, 16'd0, 16'd0);
        repeat (6) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        // largest debounce never samples
        set_config(16'hFFFF, 16'd0, 16'd0);
        repeat (4) send_tick(1'b0, 1'b0);
    endtask

    task automatic test_random_mix(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (2) begin
            set_config(kar_pkg::CFG_W'($urandom_range(3, 0)),
                       kar_pkg::CFG_W'($urandom_range(12, 0)),
                       kar_pkg::CFG_W'($urandom_range(6, 0)));
            run_random(50, 400);
        end
        set_config(16'd0, 16'd0, 16'd0);
        run_random(50, 6);
        set_config(16'hFFFF, kar_pkg::CFG_W'($urandom), kar_pkg::CFG_W'($urandom));
        run_random(25, 20);
        set_config(kar_pkg::CFG_W'($urandom_range(2, 0)), 16'hFFFF,
                   kar_pkg::CFG_W'($urandom_range(3, 0)));
        run_random(30, 40);
        set_config(kar_pkg::CFG_W'($urandom_range(2, 0)),
                   kar_pkg::CFG_W'($urandom_range(4, 0)), 16'hFFFF);
        run_random(30, 40);
        set_config(kar_pkg::CFG_W'($urandom), kar_pkg::CFG_W'($urandom),
                   kar_pkg::CFG_W'($urandom));
        run_random(25, 30);
    endtask

    task automatic test_default_settings();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_config(kar_pkg::DEBOUNCE_RST, kar_pkg::INITIAL_DELAY_RST, kar_pkg::REPEAT_RST);
        // a held through first delay and one repeat, b random
        for (int i = 0; i < 700; i++) send_tick(1'b0, 1'($urandom_range(99) < 50));
        send_tick(1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_config(16'd0, 16'd3, 16'd1);
        hold_off_cycles = 300;
        run_random(120, 30);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.button_a_level = 1'b1;
        in_ch.button_b_level = 1'b1;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = kar_pkg::REG_DEBOUNCE;
        cfg_ch.data          = '0;
        src_idle_pct         = 0;
        snk_idle_pct         = 0;
        hold_off_cycles      = 0;
        mismatches           = 0;
        reset_timers();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(20, 49);
        test_random_mix(49, 20);
        test_random_mix(0, 0);
        test_default_settings();
        test_backpressure();

        drain();
        repeat (4) @(posedge i_clk);
        if (keys_due.size() != 0) begin
            $error("%0d result items never arrived", keys_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("** key_auto_repeat_two_buttons: PASSED **");
        end else begin
            $display("** key_auto_repeat_two_buttons: FAILED **");
        end
        $finish;
    end

endmodule
